>>> src/tmsf_pkg.sv
package tmsf_pkg;

  // Channel codes
  localparam int unsigned NUM_CH = 3;
  localparam int unsigned CH_W   = 2;
  localparam logic [CH_W-1:0] CH_OFFSET = 2'd2;  // channel that gets the offset
  localparam logic [CH_W-1:0] CH_NONE   = 2'd3;  // code with no channel behind it

  // Field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned VAL_W    = 13;
  localparam int unsigned ERR_W    = 7;
  localparam int unsigned SUM_W    = 20;

  // Window and error defaults
  localparam int unsigned WINDOW_LEN_DEF = 8;
  localparam logic [ERR_W-1:0] FAIL_LIMIT = 7'd100;
  localparam logic signed [VAL_W-1:0] MIN_START = 13'sd2688;   // +168.0 degrees
  localparam logic signed [VAL_W-1:0] MAX_START = -13'sd2048;  // -128.0 degrees
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 10'sd112;  // 7.0 degrees

  // Width of the trimmed sum magnitude: at most (win-2) full-scale samples
  function automatic int unsigned mag_w(input int unsigned win);
    int unsigned lim;
    lim = (win - 2) * (1 << (SAMPLE_W - 1)) + 1;
    return $clog2(lim);
  endfunction

endpackage

>>> src/tmsf_div.sv
module tmsf_div #(
  parameter int unsigned WINDOW_LEN = tmsf_pkg::WINDOW_LEN_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         en_i,
  input  logic signed [tmsf_pkg::SUM_W:0]              t_i,
  output logic [tmsf_pkg::mag_w(WINDOW_LEN)-1:0]       q_o,
  output logic                                         neg_o
);

  localparam int unsigned T_W   = tmsf_pkg::SUM_W + 1;
  localparam int unsigned MAG_W = tmsf_pkg::mag_w(WINDOW_LEN);
  localparam logic [MAG_W-1:0] DIV_C = MAG_W'(WINDOW_LEN - 2);
  // floor(2^MAG_W / divisor); quotient estimate is low by at most one
  localparam logic [MAG_W:0] RECIP = (MAG_W+1)'((64'd1 << MAG_W) / (WINDOW_LEN - 2));

  logic signed [T_W-1:0] t_q;
  logic [T_W-1:0]        abs_full;
  logic [MAG_W-1:0]      mag_q, mag2_q;
  logic [2*MAG_W:0]      prod;
  logic [MAG_W-1:0]      q0_q;
  logic [MAG_W-1:0]      rem;
  logic [MAG_W-1:0]      q_q;
  logic [2:0]            neg_q;

  // Take magnitude, truncation toward zero then only needs the sign back
  assign abs_full = t_q[T_W-1] ? T_W'(-t_q) : T_W'(t_q);
  assign prod     = mag_q * RECIP;
  assign rem      = mag2_q - MAG_W'(q0_q * DIV_C);

  // Four stages: capture, magnitude, reciprocal multiply, correction
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q      <= t_i;
      mag_q    <= abs_full[MAG_W-1:0];
      neg_q[0] <= t_q[T_W-1];
      q0_q     <= prod[MAG_W +: MAG_W];
      mag2_q   <= mag_q;
      neg_q[1] <= neg_q[0];
      q_q      <= (rem >= DIV_C) ? q0_q + 1'b1 : q0_q;
      neg_q[2] <= neg_q[1];
    end
  end

  assign q_o   = q_q;
  assign neg_o = neg_q[2];

endmodule

>>> src/trimmed_mean_sensor_filter.sv
// Channel  Direction  Handshake                    Payload
// request  in         in_valid_i / in_stall_o      channel_i, read_failed_i, sample_i
// result   out        out_valid_o / out_stall_i    result_channel_o, filtered_valid_o,
//                                                  filtered_value_o, error_count_o
// config   in         cfg_we_i                     cfg_wdata_i (channel 2 offset)
//
// One request per cycle unless a stalled, full output register holds it back; each result
// passes the read, trim and divider stages and the output register. Per-channel window
// state sits in a three-entry RAM with a registered read; a write-back register forwards
// the last update to a request on the same channel. Reset clears the entry valid bits and
// the last filtered values, and loads the default offset of 7.0 degrees.
// A stalled, full output register stalls the whole pipeline and the request side.
module trimmed_mean_sensor_filter #(
  parameter int unsigned WINDOW_LEN = tmsf_pkg::WINDOW_LEN_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic signed [tmsf_pkg::OFFSET_W-1:0]  cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [tmsf_pkg::CH_W-1:0]             channel_i,
  input  logic                                  read_failed_i,
  input  logic signed [tmsf_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [tmsf_pkg::CH_W-1:0]             result_channel_o,
  output logic                                  filtered_valid_o,
  output logic signed [tmsf_pkg::VAL_W-1:0]     filtered_value_o,
  output logic [tmsf_pkg::ERR_W-1:0]            error_count_o
);

  localparam int unsigned SUM_W  = tmsf_pkg::SUM_W;
  localparam int unsigned VAL_W  = tmsf_pkg::VAL_W;
  localparam int unsigned ERR_W  = tmsf_pkg::ERR_W;
  localparam int unsigned CH_W   = tmsf_pkg::CH_W;
  localparam int unsigned SMP_W  = tmsf_pkg::SAMPLE_W;
  localparam int unsigned OFF_W  = tmsf_pkg::OFFSET_W;
  localparam int unsigned NUM_CH = tmsf_pkg::NUM_CH;
  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned MAG_W  = tmsf_pkg::mag_w(WINDOW_LEN);
  localparam int unsigned RES_W  = MAG_W + 2;
  localparam int unsigned DIV_LAT = 4;
  localparam logic [FILL_W-1:0] WIN_FULL = FILL_W'(WINDOW_LEN);

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic [FILL_W-1:0]       fill;
    logic [ERR_W-1:0]        fail;
  } entry_t;

  typedef struct packed {
    logic             vld;
    logic [CH_W-1:0]  ch;
    logic             done;
    logic [ERR_W-1:0] fail;
  } tag_t;

  localparam entry_t ENTRY_RESET = '{
    sum:  '0,
    lo:   tmsf_pkg::MIN_START,
    hi:   tmsf_pkg::MAX_START,
    fill: '0,
    fail: '0
  };

  logic adv, acc;

  logic signed [OFF_W-1:0] offset_q;

  // Window RAM and its per-entry valid bits
  entry_t          mem_q [NUM_CH];
  logic [NUM_CH-1:0] ent_vld_q;

  // Read stage
  logic             s1_vld_q, s1_fail_q, s1_none_q;
  logic [CH_W-1:0]  s1_ch_q;
  logic signed [SMP_W-1:0] s1_smp_q;
  entry_t           rd_q;
  logic             rd_vld_q;

  // Write-back forwarding
  entry_t           wb_q;
  logic [CH_W-1:0]  wb_ch_q;
  logic             wb_vld_q;

  // Modify results
  entry_t                  st, upd;
  logic                    done;
  logic signed [SUM_W-1:0] sum_n;
  logic signed [VAL_W-1:0] smp_x, lo_n, hi_n;
  logic [FILL_W-1:0]       fill_n;

  // Trim stage and tag line
  logic signed [SUM_W-1:0] s2_sum_q;
  logic signed [VAL_W-1:0] s2_lo_q, s2_hi_q;
  tag_t                    tag_q [DIV_LAT+1];
  tag_t                    tag_in;
  logic signed [VAL_W:0]   minmax;
  logic signed [SUM_W:0]   trim;

  logic [MAG_W-1:0]        quo;
  logic                    quo_neg;
  logic signed [RES_W-1:0] res_full;
  logic signed [VAL_W-1:0] new_val;
  tag_t                    tag_out;

  logic signed [VAL_W-1:0] last_q [NUM_CH];

  logic                    out_vld_q, out_fv_q;
  logic [CH_W-1:0]         out_ch_q;
  logic signed [VAL_W-1:0] out_val_q;
  logic [ERR_W-1:0]        out_err_q;

  // Advance whenever the output register can take a result
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign acc        = in_valid_i && adv;

  // Hold the channel 2 offset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= tmsf_pkg::OFFSET_RESET;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // Read the channel entry as the request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      rd_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= acc;
      rd_vld_q <= (channel_i != tmsf_pkg::CH_NONE) && ent_vld_q[channel_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ch_q   <= channel_i;
      s1_none_q <= (channel_i == tmsf_pkg::CH_NONE);
      s1_fail_q <= read_failed_i;
      s1_smp_q  <= sample_i;
      if (channel_i != tmsf_pkg::CH_NONE) begin
        rd_q <= mem_q[channel_i];
      end
    end
  end

  // Modify: forward the previous write, then update error count and window
  always_comb begin
    if (wb_vld_q && (wb_ch_q == s1_ch_q)) begin
      st = wb_q;
    end else if (rd_vld_q) begin
      st = rd_q;
    end else begin
      st = ENTRY_RESET;
    end
    smp_x  = {s1_smp_q[SMP_W-1], s1_smp_q};
    sum_n  = $signed(st.sum) + {{(SUM_W-SMP_W){s1_smp_q[SMP_W-1]}}, s1_smp_q};
    lo_n   = (smp_x < $signed(st.lo)) ? smp_x : $signed(st.lo);
    hi_n   = (smp_x > $signed(st.hi)) ? smp_x : $signed(st.hi);
    fill_n = st.fill + 1'b1;
    upd    = st;
    done   = 1'b0;
    if (s1_fail_q) begin
      if (st.fail < tmsf_pkg::FAIL_LIMIT) begin
        upd.fail = st.fail + 1'b1;
      end
    end else begin
      upd.fail = '0;
      if (st.fill >= WIN_FULL) begin
        upd = ENTRY_RESET;
      end else if (fill_n == WIN_FULL) begin
        upd  = ENTRY_RESET;
        done = 1'b1;
      end else begin
        upd.sum  = sum_n;
        upd.lo   = lo_n;
        upd.hi   = hi_n;
        upd.fill = fill_n;
      end
    end
  end

  // Write back and keep a copy for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      wb_vld_q  <= 1'b0;
    end else if (adv) begin
      wb_vld_q <= s1_vld_q && !s1_none_q;
      if (s1_vld_q && !s1_none_q) begin
        ent_vld_q[s1_ch_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wb_q    <= upd;
      wb_ch_q <= s1_ch_q;
      if (s1_vld_q && !s1_none_q) begin
        mem_q[s1_ch_q] <= upd;
      end
      s2_sum_q <= sum_n;
      s2_lo_q  <= lo_n;
      s2_hi_q  <= hi_n;
    end
  end

  // Tag line runs beside the divider
  always_comb begin
    tag_in.vld  = s1_vld_q;
    tag_in.ch   = s1_none_q ? tmsf_pkg::CH_NONE : s1_ch_q;
    tag_in.done = done && !s1_none_q;
    tag_in.fail = s1_none_q ? '0 : upd.fail;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DIV_LAT; i++) begin
        tag_q[i] <= '0;
      end
    end else if (adv) begin
      tag_q[0] <= tag_in;
      for (int i = 1; i <= DIV_LAT; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  // Drop largest and smallest sample
  assign minmax = {s2_hi_q[VAL_W-1], s2_hi_q} + {s2_lo_q[VAL_W-1], s2_lo_q};
  assign trim   = {s2_sum_q[SUM_W-1], s2_sum_q}
                - {{(SUM_W-VAL_W){minmax[VAL_W]}}, minmax};

  tmsf_div #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .t_i   (trim),
    .q_o   (quo),
    .neg_o (quo_neg)
  );

  // Restore sign, add the offset on channel 2
  assign tag_out  = tag_q[DIV_LAT];
  assign res_full = (quo_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo}))
                  + ((tag_out.ch == tmsf_pkg::CH_OFFSET)
                     ? $signed({{(RES_W-OFF_W){offset_q[OFF_W-1]}}, offset_q})
                     : $signed(RES_W'(0)));
  assign new_val  = res_full[VAL_W-1:0];

  // Keep the last filtered value of each channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        last_q[i] <= '0;
      end
    end else if (adv && tag_out.vld && tag_out.done) begin
      last_q[tag_out.ch] <= new_val;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= tag_out.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ch_q  <= tag_out.ch;
      out_fv_q  <= tag_out.done;
      out_err_q <= tag_out.fail;
      if (tag_out.ch == tmsf_pkg::CH_NONE) begin
        out_val_q <= '0;
      end else if (tag_out.done) begin
        out_val_q <= new_val;
      end else begin
        out_val_q <= last_q[tag_out.ch];
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign result_channel_o = out_ch_q;
  assign filtered_valid_o = out_fv_q;
  assign filtered_value_o = out_val_q;
  assign error_count_o    = out_err_q;

endmodule

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN           = int'(tmsf_pkg::WINDOW_LEN_DEF);
  localparam int TRIM_DIV      = WIN - 2;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [tmsf_pkg::CH_W-1:0] CH_OUTSIDE = 2'd0;
  localparam logic [tmsf_pkg::CH_W-1:0] CH_PIPE    = 2'd1;

  localparam logic signed [tmsf_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
    {1'b1, {(tmsf_pkg::SAMPLE_W-1){1'b0}}};
  localparam logic signed [tmsf_pkg::SAMPLE_W-1:0] SAMPLE_MAX =
    {1'b0, {(tmsf_pkg::SAMPLE_W-1){1'b1}}};
  localparam logic signed [tmsf_pkg::OFFSET_W-1:0] OFFSET_MIN =
    {1'b1, {(tmsf_pkg::OFFSET_W-1){1'b0}}};
  localparam logic signed [tmsf_pkg::OFFSET_W-1:0] OFFSET_MAX =
    {1'b0, {(tmsf_pkg::OFFSET_W-1){1'b1}}};

  typedef struct packed {
    logic [tmsf_pkg::CH_W-1:0]            channel;
    logic                                 read_failed;
    logic signed [tmsf_pkg::SAMPLE_W-1:0] sample;
  } reading_t;

  typedef struct packed {
    logic [tmsf_pkg::CH_W-1:0]         result_channel;
    logic                              filtered_valid;
    logic signed [tmsf_pkg::VAL_W-1:0] filtered_value;
    logic [tmsf_pkg::ERR_W-1:0]        error_count;
  } filtered_t;

  // Track per-channel windows and hold the filtered outputs still owed by the block
  class trimmed_mean_tracker;
    int mismatches;
    logic signed [tmsf_pkg::OFFSET_W-1:0] ch2_offset;
    logic signed [tmsf_pkg::SUM_W-1:0]    win_sum   [tmsf_pkg::NUM_CH];
    logic signed [tmsf_pkg::VAL_W-1:0]    win_min   [tmsf_pkg::NUM_CH];
    logic signed [tmsf_pkg::VAL_W-1:0]    win_max   [tmsf_pkg::NUM_CH];
    logic [4:0]                           win_fill  [tmsf_pkg::NUM_CH];
    logic [tmsf_pkg::ERR_W-1:0]           fail_run  [tmsf_pkg::NUM_CH];
    logic signed [tmsf_pkg::VAL_W-1:0]    last_mean [tmsf_pkg::NUM_CH];
    filtered_t                            owed_outputs[$];

    function new();
      mismatches = 0;
      ch2_offset = tmsf_pkg::OFFSET_RESET;
      for (int c = 0; c < tmsf_pkg::NUM_CH; c++) begin
        restart_window(c);
        fail_run[c]  = '0;
        last_mean[c] = '0;
      end
    endfunction

    function void restart_window(int c);
      win_sum[c]  = '0;
      win_min[c]  = tmsf_pkg::MIN_START;
      win_max[c]  = tmsf_pkg::MAX_START;
      win_fill[c] = '0;
    endfunction

    // Advance the channel state by one accepted request and queue its output
    function void take_reading(reading_t rd);
      filtered_t                            want;
      logic signed [tmsf_pkg::SAMPLE_W-1:0] smp;
      int                                   c;
      int                                   trimmed;
      want = '0;
      want.result_channel = rd.channel;
      smp = rd.sample;
      if (rd.channel == tmsf_pkg::CH_NONE) begin
        owed_outputs.push_back(want);
        return;
      end
      c = rd.channel;
      if (rd.read_failed) begin
        if (fail_run[c] < tmsf_pkg::FAIL_LIMIT) fail_run[c] = fail_run[c] + 1'b1;
      end else begin
        fail_run[c] = '0;
        if (win_fill[c] >= WIN) begin
          restart_window(c);
        end else begin
          win_sum[c] = win_sum[c] + smp;
          if (smp < win_min[c]) win_min[c] = smp;
          if (smp > win_max[c]) win_max[c] = smp;
          win_fill[c] = win_fill[c] + 1'b1;
          if (win_fill[c] == WIN) begin
            // drop the extremes, then divide with truncation toward zero
            trimmed = int'(win_sum[c] - win_max[c] - win_min[c]);
            trimmed = trimmed / TRIM_DIV;
            if (rd.channel == tmsf_pkg::CH_OFFSET) trimmed = trimmed + ch2_offset;
            last_mean[c] = trimmed[tmsf_pkg::VAL_W-1:0];
            want.filtered_valid = 1'b1;
            restart_window(c);
          end
        end
      end
      want.filtered_value = last_mean[c];
      want.error_count    = fail_run[c];
      owed_outputs.push_back(want);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Compare one accepted output with the oldest one owed
    task check_output(filtered_t got);
      filtered_t want;
      if (owed_outputs.size() == 0) begin
        report_mismatch("output with nothing owed, channel", got.result_channel, -1);
        return;
      end
      want = owed_outputs.pop_front();
      if (got.result_channel !== want.result_channel)
        report_mismatch("result_channel", got.result_channel, want.result_channel);
      if (got.filtered_valid !== want.filtered_valid)
        report_mismatch("filtered_valid", got.filtered_valid, want.filtered_valid);
      if (got.filtered_value !== want.filtered_value)
        report_mismatch("filtered_value", $signed(got.filtered_value),
                        $signed(want.filtered_value));
      if (got.error_count !== want.error_count)
        report_mismatch("error_count", got.error_count, want.error_count);
    endtask
  endclass

  logic                                 clk_i         = 1'b0;
  logic                                 rst_ni        = 1'b0;
  logic                                 cfg_we_i      = 1'b0;
  logic signed [tmsf_pkg::OFFSET_W-1:0] cfg_wdata_i   = '0;
  logic                                 in_valid_i    = 1'b0;
  logic                                 in_stall_o;
  logic [tmsf_pkg::CH_W-1:0]            channel_i     = '0;
  logic                                 read_failed_i = 1'b0;
  logic signed [tmsf_pkg::SAMPLE_W-1:0] sample_i      = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i   = 1'b0;
  logic [tmsf_pkg::CH_W-1:0]            result_channel_o;
  logic                                 filtered_valid_o;
  logic signed [tmsf_pkg::VAL_W-1:0]    filtered_value_o;
  logic [tmsf_pkg::ERR_W-1:0]           error_count_o;

  trimmed_mean_tracker window_model;
  bit no_idle   = 1'b0;
  int hold_left = 0;
  int cycles    = 0;

  trimmed_mean_sensor_filter #(
    .WINDOW_LEN(tmsf_pkg::WINDOW_LEN_DEF)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .channel_i       (channel_i),
    .read_failed_i   (read_failed_i),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_channel_o(result_channel_o),
    .filtered_valid_o(filtered_valid_o),
    .filtered_value_o(filtered_value_o),
    .error_count_o   (error_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the output side: long hold-off when asked, no stalls when no_idle is set, else random stalls
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 33);
    end
  end

  // Observe both handshakes on the pre-edge values
  always @(posedge clk_i) begin : watch
    reading_t  rd;
    filtered_t res;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rd.channel     = channel_i;
        rd.read_failed = read_failed_i;
        rd.sample      = sample_i;
        window_model.take_reading(rd);
      end
      if (out_valid_o && !out_stall_i) begin
        res.result_channel = result_channel_o;
        res.filtered_valid = filtered_valid_o;
        res.filtered_value = filtered_value_o;
        res.error_count    = error_count_o;
        window_model.check_output(res);
      end
    end
  end

  // Offer one request, with random idle cycles ahead of it unless no_idle is set, and hold until taken
  task automatic send_reading(input reading_t rd);
    if (!no_idle) begin
      while ($urandom_range(99) < 33) begin
        in_valid_i    <= 1'b0;
        channel_i     <= tmsf_pkg::CH_W'($urandom);
        read_failed_i <= 1'($urandom);
        sample_i      <= tmsf_pkg::SAMPLE_W'($urandom);
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    channel_i     <= rd.channel;
    read_failed_i <= rd.read_failed;
    sample_i      <= rd.sample;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic offer(input logic [tmsf_pkg::CH_W-1:0] ch, input logic failed,
                       input logic signed [tmsf_pkg::SAMPLE_W-1:0] smp);
    reading_t rd;
    rd.channel     = ch;
    rd.read_failed = failed;
    rd.sample      = smp;
    send_reading(rd);
  endtask

  function automatic reading_t random_reading();
    reading_t rd;
    int       pick;
    pick = $urandom_range(99);
    rd.channel     = (pick < 5) ? tmsf_pkg::CH_NONE
                                : tmsf_pkg::CH_W'($urandom_range(tmsf_pkg::NUM_CH - 1));
    rd.read_failed = ($urandom_range(99) < 12);
    pick = $urandom_range(99);
    if (pick < 8)       rd.sample = SAMPLE_MIN;
    else if (pick < 16) rd.sample = SAMPLE_MAX;
    else if (pick < 20) rd.sample = '0;
    else if (pick < 55) rd.sample = tmsf_pkg::SAMPLE_W'($urandom);
    else                rd.sample = tmsf_pkg::SAMPLE_W'($urandom_range(2880) - 880);
    return rd;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_reading(random_reading());
  endtask

  // Push one channel's failure count up to and past saturation
  task automatic fail_streak(input logic [tmsf_pkg::CH_W-1:0] ch, input int count);
    repeat (count) offer(ch, 1'b1, tmsf_pkg::SAMPLE_W'($urandom));
  endtask

  // Drop valid, let the last accepted request be noted, then wait for every owed output
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (window_model.owed_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic signed [tmsf_pkg::OFFSET_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    window_model.ch2_offset = value;
  endtask

  initial begin
    window_model = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: unused channel code, failures, extreme windows, failure inside a window
    offer(tmsf_pkg::CH_NONE, 1'b0, SAMPLE_MAX);
    offer(tmsf_pkg::CH_NONE, 1'b1, SAMPLE_MIN);
    offer(CH_OUTSIDE, 1'b1, '0);
    offer(CH_OUTSIDE, 1'b1, SAMPLE_MAX);
    offer(tmsf_pkg::CH_OFFSET, 1'b0, SAMPLE_MAX);
    offer(tmsf_pkg::CH_OFFSET, 1'b0, SAMPLE_MIN);
    offer(tmsf_pkg::CH_OFFSET, 1'b0, SAMPLE_MAX);
    offer(tmsf_pkg::CH_OFFSET, 1'b0, SAMPLE_MAX);
    offer(tmsf_pkg::CH_OFFSET, 1'b0, SAMPLE_MIN);
    offer(tmsf_pkg::CH_OFFSET, 1'b0, '0);
    offer(tmsf_pkg::CH_OFFSET, 1'b0, SAMPLE_MAX);
    offer(tmsf_pkg::CH_OFFSET, 1'b0, -12'sd1);
    repeat (4) offer(CH_OUTSIDE, 1'b0, SAMPLE_MIN);
    offer(CH_OUTSIDE, 1'b1, SAMPLE_MAX);
    repeat (4) offer(CH_OUTSIDE, 1'b0, SAMPLE_MIN);
    offer(CH_PIPE, 1'b1, -12'sd7);
    offer(CH_PIPE, 1'b0, -12'sd7);
    drain_outputs();

    // Lowest offset, random traffic with idling on both sides
    write_offset(OFFSET_MIN);
    send_random(300);
    drain_outputs();

    // Highest offset, back-to-back traffic with no idling at all
    write_offset(OFFSET_MAX);
    no_idle = 1'b1;
    send_random(250);
    no_idle = 1'b0;
    drain_outputs();

    // Zero offset, saturate one channel, random traffic, then fill the pipeline behind a long hold-off
    write_offset('0);
    fail_streak(CH_PIPE, 105);
    send_random(200);
    drain_outputs();
    no_idle   = 1'b1;
    hold_left = 80;
    send_random(60);
    no_idle = 1'b0;
    drain_outputs();

    // Random offset, saturate another channel, more random traffic
    write_offset(tmsf_pkg::OFFSET_W'($urandom));
    fail_streak(CH_OUTSIDE, 102);
    send_random(300);
    drain_outputs();

    if (window_model.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> trimmed_mean_sensor_filter.f
src/tmsf_pkg.sv
src/tmsf_div.sv
src/trimmed_mean_sensor_filter.sv
dv/testbench.sv
